// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define PTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check at every edge, reset included
`define PTI_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PTI_ASSERT(lbl, clk, rstn, prop, msg)

`define PTI_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/core/pti_pkg.sv -----
package pti_pkg;

  localparam int TAB_LEN    = 18;
  localparam int IDX_W      = 5;
  localparam int VAL_W      = 13;
  localparam int X_W        = 16;
  localparam int SPAN_W     = 7;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = SPAN_W + FRAC_W;
  localparam int PROD_W     = QUO_W + SPAN_W;
  localparam int SUM_W      = PROD_W - FRAC_W;
  localparam int QCNT_W     = 5;
  localparam int MCNT_W     = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TAB_LEN - 1);
  localparam logic [VAL_W-1:0] TEMP_STEP = VAL_W'(100);

  localparam logic ACT_CODE2TEMP = 1'b0;
  localparam logic ACT_TEMP2CODE = 1'b1;

  typedef struct packed {
    logic              clamp;
    logic [VAL_W-1:0]  v1;
    logic [SPAN_W-1:0] dk;
    logic [SPAN_W-1:0] dv;
    logic [SPAN_W-1:0] off;
  } seg_t;

  function automatic logic [VAL_W-1:0] tab_code(input logic [IDX_W-1:0] i);
    logic [VAL_W-1:0] c;
    case (i)
      5'd0:    c = 13'd4096;
      5'd1:    c = 13'd4174;
      5'd2:    c = 13'd4249;
      5'd3:    c = 13'd4322;
      5'd4:    c = 13'd4390;
      5'd5:    c = 13'd4458;
      5'd6:    c = 13'd4521;
      5'd7:    c = 13'd4584;
      5'd8:    c = 13'd4644;
      5'd9:    c = 13'd4701;
      5'd10:   c = 13'd4757;
      5'd11:   c = 13'd4811;
      5'd12:   c = 13'd4863;
      5'd13:   c = 13'd4912;
      5'd14:   c = 13'd4961;
      5'd15:   c = 13'd5008;
      5'd16:   c = 13'd5054;
      5'd17:   c = 13'd5098;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] tab_temp(input logic [IDX_W-1:0] i);
    logic [VAL_W-1:0] t;
    t = VAL_W'(i) * TEMP_STEP;
    return t;
  endfunction

  function automatic logic [VAL_W-1:0] tab_key(input logic act, input logic [IDX_W-1:0] i);
    logic [VAL_W-1:0] k;
    k = (act == ACT_TEMP2CODE) ? tab_temp(i) : tab_code(i);
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] tab_val(input logic act, input logic [IDX_W-1:0] i);
    logic [VAL_W-1:0] v;
    v = (act == ACT_TEMP2CODE) ? tab_code(i) : tab_temp(i);
    return v;
  endfunction

endpackage

// ----- rtl/core/pt1000_table_interpolator_core.sv -----
// Flow: when the input clamps at a table end, the end value goes straight to the output
// register; otherwise the table walk (one entry per cycle) finds h = 1..17, the index of the
// upper table entry, and the bit-serial divider and multiplier form the interpolated result.
// One word in flight: in_tready rises again once the result is loaded, so no new word is
// taken while one is in the search, divide, multiply or output phase.
// Reset: rst_n synchronous, active low; clears the sequencers and drops out_tvalid.
`include "assert_macros.svh"

module pt1000_table_interpolator_core import pti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] adc_code, [31:16] temperature
  input  logic                  in_tuser,   // [0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [12:0] result, [15:13] zero
);

  typedef enum logic [4:0] {
    T_IDLE   = 5'b00001,
    T_SEARCH = 5'b00010,
    T_DIV    = 5'b00100,
    T_MUL    = 5'b01000,
    T_OUT    = 5'b10000
  } top_st_t;

  top_st_t          st_r, st_nxt;
  logic [VAL_W-1:0] res_r, res_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [VAL_W-1:0] out_res_r, out_res_nxt;

  logic             in_fire, out_load;
  logic [X_W-1:0]   adc_code, temperature, x_sel;
  logic             srch_done, div_start, div_done, mul_start, mul_done;
  seg_t             seg;
  logic [QUO_W-1:0] quo;
  logic [VAL_W-1:0] mul_res;

  assign adc_code    = in_tdata[15:0];
  assign temperature = in_tdata[31:16];
  assign in_tready   = (st_r == T_IDLE);
  assign in_fire     = in_tvalid && in_tready;

  // negative temperature looks up as zero, which clamps to the first code
  always_comb begin
    if (in_tuser == ACT_TEMP2CODE) begin
      x_sel = temperature[X_W-1] ? '0 : temperature;
    end else begin
      x_sel = adc_code;
    end
  end

  pti_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .act   (in_tuser),
    .x     (x_sel),
    .done  (srch_done),
    .seg   (seg)
  );

  assign div_start = (st_r == T_SEARCH) && srch_done && !seg.clamp;

  pti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dv    (seg.dv),
    .dk    (seg.dk),
    .done  (div_done),
    .quo   (quo)
  );

  assign mul_start = (st_r == T_DIV) && div_done;

  pti_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .slope (quo),
    .off   (seg.off),
    .base  (seg.v1),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign out_load = (st_r == T_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    st_nxt  = st_r;
    res_nxt = res_r;
    case (st_r)
      T_IDLE: begin
        if (in_fire) begin
          st_nxt = T_SEARCH;
        end
      end
      T_SEARCH: begin
        if (srch_done) begin
          if (seg.clamp) begin
            res_nxt = seg.v1;
            st_nxt  = T_OUT;
          end else begin
            st_nxt = T_DIV;
          end
        end
      end
      T_DIV: begin
        if (div_done) begin
          st_nxt = T_MUL;
        end
      end
      T_MUL: begin
        if (mul_done) begin
          res_nxt = mul_res;
          st_nxt  = T_OUT;
        end
      end
      T_OUT: begin
        if (out_load) begin
          st_nxt = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_res_nxt    = out_res_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_res_nxt    = res_r;
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= T_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

  `PTI_ASSERT_NR(a_rst_idle, clk, !rst_n |=> (st_r == T_IDLE) && !out_tvalid, "reset did not idle the core")
  `PTI_ASSERT(a_srch_in_search, clk, rst_n, srch_done |-> (st_r == T_SEARCH), "table search finished outside search phase")
  `PTI_ASSERT(a_div_in_div, clk, rst_n, div_done |-> (st_r == T_DIV), "division finished outside divide phase")

endmodule

// ----- rtl/core/pti_search.sv -----
`include "assert_macros.svh"

module pti_search import pti_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           act,
  input  logic [X_W-1:0] x,
  output logic           done,
  output seg_t           seg
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EDGE = 3'b010,
    S_WALK = 3'b100
  } srch_st_t;

  srch_st_t         st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic             act_r, act_nxt;
  logic             done_r, done_nxt;
  seg_t             seg_r, seg_nxt;

  logic [IDX_W-1:0] idx_lo;
  logic [VAL_W-1:0] key_lo, key_hi, val_lo, val_hi, key_first, key_last;

  always_comb begin
    idx_lo    = idx_r - 1'b1;
    key_lo    = tab_key(act_r, idx_lo);
    key_hi    = tab_key(act_r, idx_r);
    val_lo    = tab_val(act_r, idx_lo);
    val_hi    = tab_val(act_r, idx_r);
    key_first = tab_key(act_r, '0);
    key_last  = tab_key(act_r, LAST_IDX);
  end

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    x_nxt    = x_r;
    act_nxt  = act_r;
    done_nxt = 1'b0;
    seg_nxt  = seg_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          x_nxt   = x;
          act_nxt = act;
          st_nxt  = S_EDGE;
        end
      end
      S_EDGE: begin
        if (x_r <= X_W'(key_first)) begin
          seg_nxt       = '0;
          seg_nxt.clamp = 1'b1;
          seg_nxt.v1    = tab_val(act_r, '0);
          done_nxt      = 1'b1;
          st_nxt        = S_IDLE;
        end else if (x_r >= X_W'(key_last)) begin
          seg_nxt       = '0;
          seg_nxt.clamp = 1'b1;
          seg_nxt.v1    = tab_val(act_r, LAST_IDX);
          done_nxt      = 1'b1;
          st_nxt        = S_IDLE;
        end else begin
          idx_nxt = IDX_W'(1);
          st_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if ((idx_r < LAST_IDX) && (X_W'(key_hi) <= x_r)) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          seg_nxt.clamp = 1'b0;
          seg_nxt.v1    = val_lo;
          seg_nxt.dk    = SPAN_W'(key_hi - key_lo);
          seg_nxt.dv    = SPAN_W'(val_hi - val_lo);
          seg_nxt.off   = SPAN_W'(x_r - X_W'(key_lo));
          done_nxt      = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      idx_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    act_r <= act_nxt;
    seg_r <= seg_nxt;
  end

  assign done = done_r;
  assign seg  = seg_r;

  `PTI_ASSERT(a_walk_idx, clk, rst_n, (st_r == S_WALK) |-> (idx_r >= IDX_W'(1)) && (idx_r <= LAST_IDX), "table walk index out of range")

endmodule

// ----- rtl/core/pti_div.sv -----
`include "assert_macros.svh"

module pti_div import pti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SPAN_W-1:0] dv,
  input  logic [SPAN_W-1:0] dk,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W-1:0] dk_r, dk_nxt;

  logic [SPAN_W:0]   trial, diff;
  logic              fits;

  always_comb begin
    trial = {rem_r, q_r[QUO_W-1]};
    diff  = trial - {1'b0, dk_r};
    fits  = trial >= {1'b0, dk_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dk_nxt   = dk_r;
    if (start) begin
      q_nxt    = {dv, FRAC_W'(0)};
      rem_nxt  = '0;
      dk_nxt   = dk;
      cnt_nxt  = QCNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[QUO_W-2:0], fits};
      rem_nxt = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dk_r  <= dk_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

  `PTI_ASSERT(a_rem_below_dk, clk, rst_n, busy_r |-> (rem_r < dk_r), "partial remainder not below divisor")
  `PTI_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> ($past(busy_r) && !busy_r), "quotient done without a division in flight")

endmodule

// ----- rtl/core/pti_mul.sv -----
module pti_mul import pti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUO_W-1:0]  slope,
  input  logic [SPAN_W-1:0] off,
  input  logic [VAL_W-1:0]  base,
  output logic              done,
  output logic [VAL_W-1:0]  res
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_STEP = 3'b010,
    M_SUM  = 3'b100
  } mul_st_t;

  mul_st_t           st_r, st_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [SPAN_W-1:0] mplier_r, mplier_nxt;
  logic [VAL_W-1:0]  base_r, base_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    sum        = SUM_W'(base_r) + acc_r[PROD_W-1:FRAC_W];
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    mplier_nxt = mplier_r;
    base_nxt   = base_r;
    res_nxt    = res_r;
    case (st_r)
      M_IDLE: begin
        if (start) begin
          mcand_nxt  = PROD_W'(slope);
          mplier_nxt = off;
          acc_nxt    = '0;
          base_nxt   = base;
          cnt_nxt    = MCNT_W'(SPAN_W - 1);
          st_nxt     = M_STEP;
        end
      end
      M_STEP: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[SPAN_W-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          st_nxt = M_SUM;
        end
      end
      M_SUM: begin
        res_nxt  = sum[VAL_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = M_IDLE;
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    mplier_r <= mplier_nxt;
    base_r   <= base_nxt;
    res_r    <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
